@@ rtl/itoa_pkg.sv @@
// itoa_pkg: shared types, constants and the digit-to-character mapping
// for the integer to base ascii converter
// no dependencies
`timescale 1ns / 1ps

package itoa_pkg;

	// width of the signed input value
	localparam int unsigned ValueWidth = 32;
	// exact magnitude of the most negative value needs one more bit
	localparam int unsigned MagWidth   = ValueWidth + 1;
	localparam int unsigned BaseWidth  = 6;
	localparam int unsigned DigitWidth = 6;
	localparam int unsigned CharWidth  = 8;

	localparam logic [BaseWidth-1:0]  BaseMin       = BaseWidth'(2);
	localparam logic [BaseWidth-1:0]  BaseMax       = BaseWidth'(35);
	localparam logic [DigitWidth-1:0] DecimalDigits = DigitWidth'(10);

	localparam logic [CharWidth-1:0] CharZero  = 8'h30; // '0'
	localparam logic [CharWidth-1:0] CharLowA  = 8'h61; // 'a'
	localparam logic [CharWidth-1:0] CharMinus = 8'h2d; // '-'
	localparam logic [CharWidth-1:0] CharNone  = 8'h00;

	typedef struct packed {
		logic signed [ValueWidth-1:0] value;
		logic        [BaseWidth-1:0]  base;
	} req_t;

	typedef struct packed {
		logic [CharWidth-1:0] character;
		logic                 last;
		logic                 bad_base;
	} result_t;

	// digit value to ascii: '0'..'9' then 'a' onward
	function automatic logic [CharWidth-1:0] digit_char(input logic [DigitWidth-1:0] d);
		logic [CharWidth-1:0] ch;
		if (d < DecimalDigits) begin
			ch = CharZero + CharWidth'(d);
		end else begin
			ch = CharLowA + CharWidth'(d - DecimalDigits);
		end
		return ch;
	endfunction

endpackage

@@ rtl/integer_to_base_ascii.sv @@
// integer_to_base_ascii: signed integer to ascii text in a base from 2 to 35
// one shared restoring divide step, a digit store in flops and a small sequencer
// depends on itoa_pkg
`timescale 1ns / 1ps

//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+-------------------------------
//  request   | in        | start & !busy             | req    (value, base)
//  result    | out       | strobe, one cycle, no hold| result (character, last, bad_base)
//
//  sequence: a bad base gives its single result the cycle after the request, and busy
//  stays low. a valid request with D digits runs the shared divide step once for each
//  digit (one quotient bit per cycle over the 33-bit magnitude), then the characters
//  go out one per cycle: D digits plus one for a minus sign.
//  reset: async, active low, returns the sequencer to idle with no strobe pending.
//  stalls: none on the result side; requests are held off only by busy.

module integer_to_base_ascii (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  itoa_pkg::req_t     req,
	output logic               strobe,
	output itoa_pkg::result_t  result
);

	localparam int unsigned ValueWidth = itoa_pkg::ValueWidth;
	localparam int unsigned MagWidth   = itoa_pkg::MagWidth;
	localparam int unsigned BaseWidth  = itoa_pkg::BaseWidth;
	localparam int unsigned DigitWidth = itoa_pkg::DigitWidth;
	// digit store index and a count that can also hold the full depth
	localparam int unsigned IdxWidth   = $clog2(ValueWidth);
	localparam int unsigned CntWidth   = IdxWidth + 1;
	// divide step counter covers one pass over the magnitude
	localparam int unsigned StepWidth  = $clog2(MagWidth);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                  state_q;
	logic [MagWidth-1:0]     mag_q;       // dividend, turns into the quotient
	logic [DigitWidth-1:0]   rem_q;       // partial remainder, below base while dividing
	logic [BaseWidth-1:0]    base_q;
	logic                    neg_q;
	logic [StepWidth-1:0]    step_q;
	logic [CntWidth-1:0]     count_q;     // digits stored so far
	logic [IdxWidth-1:0]     idx_q;       // emit pointer, counts down
	logic                    strobe_q;
	itoa_pkg::result_t       result_q;

	// digits land least significant first
	logic [DigitWidth-1:0]   digit_store_q [ValueWidth];

	// request decode
	logic                    accept;
	logic                    base_ok;
	logic                    value_neg;
	logic [MagWidth-1:0]     value_sext;
	logic [MagWidth-1:0]     value_mag;

	// shared restoring divide step
	logic [DigitWidth:0]     rem_shift;
	logic                    q_bit;
	logic [DigitWidth:0]     rem_sub;
	logic [DigitWidth-1:0]   rem_next;
	logic [MagWidth-1:0]     mag_next;
	logic                    digit_done;
	logic                    conv_done;

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	assign accept     = start && !busy;
	assign base_ok    = (req.base >= itoa_pkg::BaseMin) && (req.base <= itoa_pkg::BaseMax);
	assign value_neg  = req.value[ValueWidth-1];
	// sign extend one bit, then negate: exact for the most negative value
	assign value_sext = {req.value[ValueWidth-1], req.value};
	assign value_mag  = value_neg ? (MagWidth'(0) - value_sext) : value_sext;

	// shift in the next dividend bit, subtract the base when it fits
	assign rem_shift  = {rem_q, mag_q[MagWidth-1]};
	assign q_bit      = (rem_shift >= {1'b0, base_q});
	assign rem_sub    = rem_shift - {1'b0, base_q};
	assign rem_next   = q_bit ? rem_sub[DigitWidth-1:0] : rem_shift[DigitWidth-1:0];
	assign mag_next   = {mag_q[MagWidth-2:0], q_bit};

	assign digit_done = (step_q == StepWidth'(MagWidth - 1));
	// stop on a zero quotient or when the store is full
	assign conv_done  = (mag_next == '0) || (count_q == CntWidth'(ValueWidth - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mag_q    <= '0;
			rem_q    <= '0;
			base_q   <= '0;
			neg_q    <= 1'b0;
			step_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					strobe_q <= accept && !base_ok;
					if (accept) begin
						if (!base_ok) begin
							// single flagged result, nothing else changes
							result_q.character <= itoa_pkg::CharNone;
							result_q.last      <= 1'b1;
							result_q.bad_base  <= 1'b1;
						end else begin
							mag_q   <= value_mag;
							rem_q   <= '0;
							base_q  <= req.base;
							neg_q   <= value_neg;
							step_q  <= '0;
							count_q <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					strobe_q <= 1'b0;
					mag_q    <= mag_next;
					if (digit_done) begin
						// remainder is the digit, quotient restarts as the dividend
						step_q  <= '0;
						rem_q   <= '0;
						count_q <= count_q + CntWidth'(1);
						if (conv_done) begin
							idx_q   <= count_q[IdxWidth-1:0];
							state_q <= neg_q ? ST_SIGN : ST_EMIT;
						end
					end else begin
						step_q <= step_q + StepWidth'(1);
						rem_q  <= rem_next;
					end
				end
				ST_SIGN: begin
					strobe_q           <= 1'b1;
					result_q.character <= itoa_pkg::CharMinus;
					result_q.last      <= 1'b0;
					result_q.bad_base  <= 1'b0;
					state_q            <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q           <= 1'b1;
					result_q.character <= itoa_pkg::digit_char(digit_store_q[idx_q]);
					result_q.last      <= (idx_q == '0);
					result_q.bad_base  <= 1'b0;
					idx_q              <= idx_q - IdxWidth'(1);
					if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					strobe_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	// digit store write, payload only
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && digit_done) begin
			digit_store_q[count_q[IdxWidth-1:0]] <= rem_next;
		end
	end

	// a flagged result carries no text and ends the request
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.bad_base |-> result.last && (result.character == itoa_pkg::CharNone))
		else $error("bad base result malformed");

	// divider remainder stays below the base
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < base_q))
		else $error("remainder not below base");

	// only valid bases reach the divider
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (base_q >= itoa_pkg::BaseMin) && (base_q <= itoa_pkg::BaseMax))
		else $error("divider running with bad base");

	// busy drops exactly as the final character goes out
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && result.last && !result.bad_base)
		else $error("busy fell without final character");

	// the sign is always followed by a digit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |=> (state_q == ST_EMIT))
		else $error("sign not followed by digits");

endmodule
